### rtl/core/zcl_pkg.sv
// ----------------------------------------------------------------------------
// zcl_pkg
// Shared types and constants of the zero-cross lamp scr driver.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package zcl_pkg;

  localparam int unsigned MAX_BANKS = 3;
  localparam int unsigned COL_W     = 15;
  localparam int unsigned OP_W      = 2;
  localparam int unsigned DATA_W    = 8;
  localparam int unsigned LAMP_COL_W = 4;

  localparam logic [COL_W-1:0]      COL_MASK  = 15'h7FFF;
  localparam logic [LAMP_COL_W-1:0] ADDR_MASK = 4'hF;
  localparam int unsigned           GATE_BIT  = 1;
  localparam int unsigned           STROBE_BIT = 0;
  localparam int unsigned           BANK_SEL_LSB = 5;

  typedef enum logic [OP_W-1:0] {
    OP_PORT_A     = 2'd0,
    OP_STROBE     = 2'd1,
    OP_ZERO_CROSS = 2'd2,
    OP_PORT2      = 2'd3
  } zcl_op_e;

  typedef struct packed {
    logic [MAX_BANKS-1:0][COL_W-1:0] conduct;
    logic [MAX_BANKS-1:0]            changed;
    logic                            timer_irq;
    logic                            phase_b;
  } zcl_result_t;

endpackage

`default_nettype wire

### rtl/core/zcl_lamp_core.sv
// ----------------------------------------------------------------------------
// zcl_lamp_core
// Lamp state registers and the single-pass update for one word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module zcl_lamp_core #(
  parameter int unsigned NUM_BANKS   = 3,
  parameter int unsigned NUM_COLUMNS = 15
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       fire_i,
  input  wire zcl_pkg::zcl_op_e           op_i,
  input  wire logic [zcl_pkg::DATA_W-1:0] data_i,
  output zcl_pkg::zcl_result_t            res_o
);
  import zcl_pkg::*;

  localparam logic [LAMP_COL_W:0] COL_LIMIT = (LAMP_COL_W+1)'(NUM_COLUMNS);

  logic [DATA_W-1:0]                port_a_q, port_a_d;
  logic                             strobe_q, strobe_d;
  logic [LAMP_COL_W-1:0]            column_q, column_d;
  logic                             phase_a_q, phase_a_d;
  logic                             gate_q, gate_d;
  logic [NUM_BANKS-1:0][COL_W-1:0]  drivers_q, drivers_d;
  logic [NUM_BANKS-1:0][COL_W-1:0]  conduct_q, conduct_d;
  logic [NUM_BANKS-1:0]             changed;
  logic [MAX_BANKS-1:0]             bank_sel;
  logic [COL_W-1:0]                 onehot;
  logic [COL_W-1:0]                 drv_new;
  logic                             refresh;

  always_comb begin
    port_a_d  = port_a_q;
    strobe_d  = strobe_q;
    column_d  = column_q;
    phase_a_d = phase_a_q;
    gate_d    = gate_q;
    refresh   = 1'b1;
    case (op_i)
      OP_PORT_A: begin
        port_a_d = data_i;
      end
      OP_STROBE: begin
        if (strobe_q && !data_i[STROBE_BIT]) begin
          column_d = port_a_q[LAMP_COL_W-1:0] & ADDR_MASK;
        end
        strobe_d = data_i[STROBE_BIT];
      end
      OP_ZERO_CROSS: begin
        phase_a_d = ~phase_a_q;
      end
      OP_PORT2: begin
        gate_d  = data_i[GATE_BIT];
        refresh = 1'b0;
      end
      default: begin
        refresh = 1'b0;
      end
    endcase

    // inverted bank enables on port a bits 7..5
    bank_sel = ~port_a_d[BANK_SEL_LSB +: MAX_BANKS];
    if ({1'b0, column_d} < COL_LIMIT) begin
      onehot = (COL_W'(1) << column_d) & COL_MASK;
    end else begin
      onehot = '0;
    end

    drv_new = '0;
    for (int b = 0; b < NUM_BANKS; b++) begin
      drv_new = bank_sel[b] ? onehot : '0;
      if (refresh) begin
        drivers_d[b] = drv_new;
        conduct_d[b] = ((op_i == OP_ZERO_CROSS) ? drivers_q[b] : conduct_q[b]) | drv_new;
      end else begin
        drivers_d[b] = drivers_q[b];
        conduct_d[b] = conduct_q[b];
      end
      changed[b] = (conduct_d[b] != conduct_q[b]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      port_a_q  <= '0;
      strobe_q  <= 1'b0;
      column_q  <= '0;
      phase_a_q <= 1'b0;
      gate_q    <= 1'b0;
      drivers_q <= '0;
      conduct_q <= '0;
    end else if (fire_i) begin
      port_a_q  <= port_a_d;
      strobe_q  <= strobe_d;
      column_q  <= column_d;
      phase_a_q <= phase_a_d;
      gate_q    <= gate_d;
      drivers_q <= drivers_d;
      conduct_q <= conduct_d;
    end
  end

  for (genvar g = 0; g < MAX_BANKS; g++) begin : g_bank
    if (g < NUM_BANKS) begin : g_used
      assign res_o.conduct[g] = conduct_d[g];
      assign res_o.changed[g] = changed[g];
    end else begin : g_unused
      assign res_o.conduct[g] = '0;
      assign res_o.changed[g] = 1'b0;
    end
  end

  assign res_o.timer_irq = phase_a_d & ~gate_d;
  assign res_o.phase_b   = ~phase_a_d;

endmodule

`default_nettype wire

### rtl/core/zero_cross_lamp_scr_driver.sv
// ----------------------------------------------------------------------------
// zero_cross_lamp_scr_driver
// Lamp scr bank driver: port a, strobe, port 2 and zero-cross words in,
// conduct masks, change flags and phase lines out.
// ----------------------------------------------------------------------------
// path: an accepted word passes the input register, then the result register
// throughput: one word per cycle while the result is not stalled, set by the state update
// a stalled result holds while the input register still takes one word
// reset: asynchronous, clears lamp state, phase, gate and both valid flags
`timescale 1ns / 1ps
`default_nettype none

module zero_cross_lamp_scr_driver #(
  parameter int unsigned NUM_BANKS   = 3,
  parameter int unsigned NUM_COLUMNS = 15
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire logic [zcl_pkg::OP_W-1:0]   operation_i,
  input  wire logic [zcl_pkg::DATA_W-1:0] data_i,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output logic [zcl_pkg::COL_W-1:0]       conduct_bank0_o,
  output logic [zcl_pkg::COL_W-1:0]       conduct_bank1_o,
  output logic [zcl_pkg::COL_W-1:0]       conduct_bank2_o,
  output logic [zcl_pkg::MAX_BANKS-1:0]   changed_mask_o,
  output logic                            timer_irq_o,
  output logic                            phase_b_line_o
);
  import zcl_pkg::*;

  logic              in_valid_q;
  zcl_op_e           in_op_q;
  logic [DATA_W-1:0] in_data_q;
  logic              out_valid_q;
  zcl_result_t       res_d, res_q;
  logic              advance;
  logic              fire;
  logic              in_accept;

  assign advance    = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        in_valid_q <= 1'b1;
      end else if (fire) begin
        in_valid_q <= 1'b0;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_op_q   <= zcl_op_e'(operation_i);
      in_data_q <= data_i;
    end
    if (fire) begin
      res_q <= res_d;
    end
  end

  zcl_lamp_core #(
    .NUM_BANKS   (NUM_BANKS),
    .NUM_COLUMNS (NUM_COLUMNS)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .op_i   (in_op_q),
    .data_i (in_data_q),
    .res_o  (res_d)
  );

  assign out_valid_o     = out_valid_q;
  assign conduct_bank0_o = res_q.conduct[0];
  assign conduct_bank1_o = res_q.conduct[1];
  assign conduct_bank2_o = res_q.conduct[2];
  assign changed_mask_o  = res_q.changed;
  assign timer_irq_o     = res_q.timer_irq;
  assign phase_b_line_o  = res_q.phase_b;

endmodule

`default_nettype wire

### rtl/core/zcl_checker.sv
// ----------------------------------------------------------------------------
// zcl_checker
// Port-level checks of the lamp scr driver, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module zcl_checker (
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       in_valid_i,
  input wire logic                       in_stall_o,
  input wire logic [zcl_pkg::OP_W-1:0]   operation_i,
  input wire logic [zcl_pkg::DATA_W-1:0] data_i,
  input wire logic                       out_valid_o,
  input wire logic                       out_stall_i,
  input wire logic [zcl_pkg::COL_W-1:0]  conduct_bank0_o,
  input wire logic [zcl_pkg::COL_W-1:0]  conduct_bank1_o,
  input wire logic [zcl_pkg::COL_W-1:0]  conduct_bank2_o,
  input wire logic [zcl_pkg::MAX_BANKS-1:0] changed_mask_o,
  input wire logic                       timer_irq_o,
  input wire logic                       phase_b_line_o
);

  // irq needs phase a, phase b is its inverse
  a_phase_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(timer_irq_o && phase_b_line_o))
    else $error("timer irq and phase b both high");

  // input only backs up behind a stalled result
  a_stall_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a stalled result");

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(conduct_bank0_o)
      && $stable(conduct_bank1_o) && $stable(conduct_bank2_o)
      && $stable(changed_mask_o) && $stable(timer_irq_o) && $stable(phase_b_line_o)))
    else $error("stalled result word changed");

  // a stalled input word holds
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_stall_o) |=> (in_valid_i && $stable(operation_i)
      && $stable(data_i)))
    else $error("stalled input word changed");

  // a word accepted while no result is held leads to a result through the input and result registers
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && !out_valid_o) |=> ##1 out_valid_o)
    else $error("accepted word produced no result");

endmodule

bind zero_cross_lamp_scr_driver zcl_checker u_zcl_checker (.*);

`default_nettype wire
